@@ src/fsc_pkg.sv @@
// Shared widths, result codes and defaults for the frame-transfer smear correction block.
package fsc_pkg;

    localparam int PIX_W     = 16;
    localparam int COL_W     = 12;
    localparam int SCALE_W   = 16;
    localparam int EST_W     = 32;
    localparam int OUT_W     = 24;
    localparam int COLUMNS_DEF = 4096;

    // Result buffer depth; must cover the three pipeline stages plus one.
    localparam int RBUF_DEPTH = 8;

    typedef enum logic [1:0] {
        KIND_CORRECTED = 2'd0,
        KIND_PASS      = 2'd1,
        KIND_NULL      = 2'd2
    } t_kind;

endpackage

@@ src/fsc_if.sv @@
// Valid/ready channel interfaces: pixel requests, results and the scale register write.
interface fsc_pix_if import fsc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   pixel_value;
    logic               pixel_valid;
    logic [COL_W-1:0]   column;
    logic               first_line;

    modport source (output valid, pixel_value, pixel_valid, column, first_line, input ready);
    modport sink   (input valid, pixel_value, pixel_valid, column, first_line, output ready);
endinterface

interface fsc_res_if import fsc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OUT_W-1:0]   corrected_value;
    t_kind              result_kind;

    modport source (output valid, corrected_value, result_kind, input ready);
    modport sink   (input valid, corrected_value, result_kind, output ready);
endinterface

interface fsc_cfg_if import fsc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SCALE_W-1:0] smear_scale;

    modport source (output valid, smear_scale, input ready);
    modport sink   (input valid, smear_scale, output ready);
endinterface

@@ src/frame_transfer_smear_correction.sv @@
// Top level: per-column smear estimate kept in a RAM, updated by a pipelined read-modify-write.
//
// Usage:
//   i_pix  : pixel requests in raster order (value, valid flag, column, first-line flag).
//   o_res  : one result per request, same order: corrected 16.8 value and kind
//            (corrected, passed through, or null when pixel minus smear rounds to <= 0).
//   i_cfg  : write of smear_scale (unsigned Q0.16); always ready. Write only while idle.
// Pipeline: a request goes through the RAM read, the multiply, the estimate add and
//   write-back, and the difference into the result buffer before its result is on o_res.
// Throughput: one request per cycle while the result buffer has room. A request on the
//   column of the request in stage 1 is held: the estimate of a column comes around the
//   multiply/add loop too late for a read issued right behind it, so it waits. A request
//   whose read lands with that write-back picks up the new estimate through a bypass.
// Reset: control state and smear_scale clear to zero. The estimate RAM is not cleared;
//   each column must be seeded by a first-line pixel before later lines read it.
// Stall: results collect in an 8-entry buffer. The input keeps accepting while the
//   buffer plus the pipeline holds fewer than 8 results, so a stalled receiver only
//   stops the input once that space is spoken for; nothing is dropped.
module frame_transfer_smear_correction
    import fsc_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fsc_cfg_if.sink   i_cfg,
    fsc_pix_if.sink   i_pix,
    fsc_res_if.source o_res
);

    localparam int ADDR_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RB_AW  = $clog2(RBUF_DEPTH);
    localparam int RB_CW  = RB_AW + 1;
    localparam int PROD_W = EST_W + SCALE_W + 1;   // estimate * (1 - scale)

    // ---------------- configuration ----------------
    logic [SCALE_W-1:0] r_scale;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= '0;
        end else if (i_cfg.valid) begin
            r_scale <= i_cfg.smear_scale;
        end
    end

    // ---------------- pipeline registers ----------------
    // Stage 1: RAM read returns, products formed.
    logic               r1_v, r1_range, r1_valid, r1_first, r1_we;
    logic [PIX_W-1:0]   r1_pix;
    logic [COL_W-1:0]   r1_col;
    logic [ADDR_W-1:0]  r1_addr;
    logic [EST_W-1:0]   r_rd;
    // Stage 2: estimate sum, RAM write-back.
    logic               r2_v, r2_range, r2_valid, r2_first, r2_we;
    logic [PIX_W-1:0]   r2_pix;
    logic [ADDR_W-1:0]  r2_addr;
    logic [EST_W-1:0]   r2_ppix;
    logic [PROD_W-1:0]  r2_pold;
    // Stage 3: difference and rounding, then into the result buffer.
    logic               r3_v, r3_pass, r3_we;
    logic [PIX_W-1:0]   r3_pix;
    logic [ADDR_W-1:0]  r3_addr;
    logic [EST_W-1:0]   r3_est;

    logic [EST_W-1:0]   r_mem [COLUMNS];

    // Result buffer
    logic [OUT_W-1:0]   r_rb_val  [RBUF_DEPTH];
    t_kind              r_rb_kind [RBUF_DEPTH];
    logic [RB_AW-1:0]   r_rb_wr, r_rb_rd;
    logic [RB_CW-1:0]   r_rb_cnt;

    // ---------------- input side ----------------
    logic               in_range, hazard, accept, pop;
    logic [ADDR_W-1:0]  in_addr;
    logic [RB_CW-1:0]   in_flight;

    assign in_range = (32'(i_pix.column) < COLUMNS);
    assign in_addr  = ADDR_W'(i_pix.column);

    // Same column as the request now in stage 1: its estimate is not ready yet.
    assign hazard    = r1_v && r1_we && (r1_col == i_pix.column);
    assign in_flight = r_rb_cnt + RB_CW'(r1_v) + RB_CW'(r2_v) + RB_CW'(r3_v);

    assign i_pix.ready = (in_flight < RB_CW'(RBUF_DEPTH)) && !hazard;
    assign accept      = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_pix   <= i_pix.pixel_value;
            r1_valid <= i_pix.pixel_valid;
            r1_first <= i_pix.first_line;
            r1_range <= in_range;
            r1_col   <= i_pix.column;
            r1_addr  <= in_addr;
            // every in-range write except an invalid pixel on a later line
            r1_we    <= in_range && (i_pix.pixel_valid || i_pix.first_line);
        end
    end

    // ---------------- estimate RAM ----------------
    logic [EST_W-1:0] est_wdata;

    always_ff @(posedge i_clk) begin
        if (r2_v && r2_we) begin
            r_mem[r2_addr] <= est_wdata;
        end
        if (accept && in_range) begin
            r_rd <= r_mem[in_addr];
        end
    end

    // ---------------- stage 1: multiply ----------------
    logic             fwd;
    logic [EST_W-1:0] old_est;

    // Write-back of the request now in stage 3 landed on the same edge as this read.
    assign fwd     = r3_v && r3_we && (r3_addr == r1_addr);
    assign old_est = fwd ? r3_est : r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_pix   <= r1_pix;
        r2_valid <= r1_valid;
        r2_first <= r1_first;
        r2_range <= r1_range;
        r2_we    <= r1_we;
        r2_addr  <= r1_addr;
        r2_ppix  <= EST_W'(r1_pix) * EST_W'(r_scale);
        r2_pold  <= PROD_W'(old_est)
                  * PROD_W'((SCALE_W+1)'(1 << SCALE_W) - (SCALE_W+1)'(r_scale));
    end

    // ---------------- stage 2: new estimate ----------------
    logic [PROD_W-SCALE_W-1:0] part_old;
    logic [EST_W+1:0]          est_sum;
    logic [EST_W-1:0]          est_sat;

    // round to nearest, ties up
    assign part_old = (PROD_W-SCALE_W)'((r2_pold + PROD_W'(1 << (SCALE_W-1))) >> SCALE_W);
    assign est_sum  = (EST_W+2)'(r2_ppix) + (EST_W+2)'(part_old);
    assign est_sat  = (est_sum > (EST_W+2)'({EST_W{1'b1}})) ? {EST_W{1'b1}}
                                                             : est_sum[EST_W-1:0];

    always_comb begin
        if (r2_first) begin
            est_wdata = r2_valid ? r2_ppix : '0;
        end else begin
            est_wdata = est_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_pix  <= r2_pix;
        r3_est  <= est_wdata;
        r3_we   <= r2_we;
        r3_addr <= r2_addr;
        r3_pass <= !r2_range || !r2_valid || r2_first;
    end

    // ---------------- stage 3: difference ----------------
    logic [EST_W:0]   pfix;
    logic [EST_W:0]   diff_rnd;
    logic [OUT_W-1:0] q;
    logic [OUT_W-1:0] res_val;
    t_kind            res_kind;

    assign pfix     = {1'b0, r3_pix, {(EST_W-PIX_W){1'b0}}};
    assign diff_rnd = pfix - {1'b0, r3_est} + (EST_W+1)'(128);
    assign q        = diff_rnd[OUT_W+7:8];

    always_comb begin
        if (r3_pass) begin
            res_val  = {r3_pix, 8'd0};
            res_kind = KIND_PASS;
        end else if ((pfix <= {1'b0, r3_est}) || (q == '0)) begin
            res_val  = '0;
            res_kind = KIND_NULL;
        end else begin
            res_val  = q;
            res_kind = KIND_CORRECTED;
        end
    end

    // ---------------- result buffer ----------------
    assign pop = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (r3_v) begin
            r_rb_val[r_rb_wr]  <= res_val;
            r_rb_kind[r_rb_wr] <= res_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rb_wr  <= '0;
            r_rb_rd  <= '0;
            r_rb_cnt <= '0;
        end else begin
            if (r3_v) begin
                r_rb_wr <= r_rb_wr + 1'b1;
            end
            if (pop) begin
                r_rb_rd <= r_rb_rd + 1'b1;
            end
            r_rb_cnt <= r_rb_cnt + RB_CW'(r3_v) - RB_CW'(pop);
        end
    end

    assign o_res.valid           = (r_rb_cnt != '0);
    assign o_res.corrected_value = r_rb_val[r_rb_rd];
    assign o_res.result_kind     = r_rb_kind[r_rb_rd];

endmodule
